// File: rtl/rectangle_overlap_pair_counter_unit_assert.svh
// Assertion macros shared by the rectangle overlap pair counter RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef RECTANGLE_OVERLAP_PAIR_COUNTER_UNIT_ASSERT_SVH
`define RECTANGLE_OVERLAP_PAIR_COUNTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define ROCT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("roct assertion failed");
// next-cycle implication
`define ROCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("roct assertion failed");
`else
`define ROCT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ROCT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/roct_pkg.sv
// Shared constants, codes and structs of the rectangle overlap pair counter.
// No dependencies; roct_if, the top level and roct_walker import this package.
package roct_pkg;

   localparam int COORD_BITS  = 10;
   localparam int MAX_ACTIVE  = 4096;
   localparam int ADDR_BITS   = COORD_BITS + 1;
   localparam int TREE_DEPTH  = 2 ** ADDR_BITS;
   localparam int CNT_BITS    = $clog2(MAX_ACTIVE + 1);
   localparam int OVL_BITS    = 12;
   localparam int OVL_MAX     = 2 ** OVL_BITS - 1;
   localparam int TOTAL_BITS  = 32;
   localparam int STATUS_BITS = 2;
   localparam int SUM_BITS    = (CNT_BITS > OVL_BITS) ? CNT_BITS : OVL_BITS + 1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_ACTIVE = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_INC   = 2'd1;
   localparam logic [1:0] OP_DEC   = 2'd2;
   localparam logic [1:0] OP_LEAF  = 2'd3;

   typedef struct packed {
      logic                  start;
      logic [1:0]            op;
      logic [COORD_BITS-1:0] coord;
   } walk_cmd_type;

   typedef struct packed {
      logic                idle;
      logic                done;
      logic [CNT_BITS-1:0] value;
   } walk_stat_type;

endpackage

// File: rtl/roct_if.sv
// Valid/ready channel interfaces for event transactions and result transactions.
// Depends on roct_pkg for the field widths.
interface roct_req_if;
   import roct_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] bottom_y;
   logic [COORD_BITS-1:0] top_y;
   modport source (output valid, cmd, bottom_y, top_y, input ready);
   modport sink   (input valid, cmd, bottom_y, top_y, output ready);
endinterface

interface roct_rsp_if;
   import roct_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [OVL_BITS-1:0]    new_overlaps;
   logic [TOTAL_BITS-1:0]  total_pairs;
   logic [STATUS_BITS-1:0] status;
   modport source (output valid, new_overlaps, total_pairs, status, input ready);
   modport sink   (input valid, new_overlaps, total_pairs, status, output ready);
endinterface

// File: rtl/rectangle_overlap_pair_counter_unit.sv
// Top level of the rectangle overlap pair counter: event sequencer, pair total,
// active count and result register. Depends on roct_pkg, roct_if, roct_walker
// and the assertion macro header.
//
// Usage:
//   req_ch carries one sweep event per transaction (cmd, bottom_y, top_y), fed in
//   x order with the ends at an x ahead of the begins at that x. rsp_ch returns
//   exactly one result transaction per event (new_overlaps, total_pairs, status).
//   The wait from acceptance to rsp_ch.valid depends on the event kind, as the
//   two tree walkers step one tree node per cycle through their RAM read port:
//     begin, non-flat interval:  query walk, then update walk
//     begin, flat interval:      update walk only
//     end:                       leaf read, then update walk
//     end with an inactive leaf: leaf read only
//     rejected (full or empty):  neither walker runs
//   One event is in work at a time; req_ch.ready is high only between events and
//   rises on the edge that loads the result, so the next event is accepted in the
//   cycle after that at the earliest.
//   After reset both trees are cleared one address per cycle, all
//   2^(COORD_BITS+1) addresses (2048); req_ch.ready stays low meanwhile.
//   A stalled rsp_ch holds its result register; the next event is still
//   accepted and finishes its work, then waits until that register frees.
`include "rectangle_overlap_pair_counter_unit_assert.svh"

module rectangle_overlap_pair_counter_unit (
   input logic        clock,
   input logic        reset,
   roct_req_if.sink   req_ch,
   roct_rsp_if.source rsp_ch
);
   import roct_pkg::*;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_QUERY = 3'd2;
   localparam logic [2:0] S_ACC   = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_UPD   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [COORD_BITS-1:0]  lo_ff, lo_in;
   logic [COORD_BITS-1:0]  hi_ff, hi_in;
   logic [SUM_BITS-1:0]    ovl_ff, ovl_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [TOTAL_BITS-1:0]  pair_ff, pair_in;
   logic [CNT_BITS-1:0]    active_ff, active_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OVL_BITS-1:0]    rsp_ovl_ff, rsp_ovl_in;
   logic [TOTAL_BITS-1:0]  rsp_total_ff, rsp_total_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   logic                   req_ready;
   logic                   accept;
   logic                   swap;
   logic [COORD_BITS-1:0]  lo_new;
   logic [COORD_BITS-1:0]  hi_new;
   logic                   out_free;
   logic                   walk_done;
   logic [TOTAL_BITS:0]    pair_sum;

   walk_cmd_type           top_cmd;
   walk_cmd_type           bot_cmd;
   walk_stat_type          top_stat;
   walk_stat_type          bot_stat;

   // top_cmd walks the tree of active top edges, bot_cmd the bottom edges
   roct_walker u_top_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (top_cmd),
      .stat  (top_stat)
   );

   roct_walker u_bot_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (bot_cmd),
      .stat  (bot_stat)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_ch.valid && req_ready;

   // order the edges so that lo <= hi
   assign swap   = req_ch.bottom_y > req_ch.top_y;
   assign lo_new = swap ? req_ch.top_y : req_ch.bottom_y;
   assign hi_new = swap ? req_ch.bottom_y : req_ch.top_y;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   // both walkers run the same number of steps, so they finish together
   assign walk_done = top_stat.done && bot_stat.done;
   assign pair_sum  = {1'b0, pair_ff} + (TOTAL_BITS + 1)'(ovl_ff);

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ovl_in        = ovl_ff;
      status_in     = status_ff;
      pair_in       = pair_ff;
      active_in     = active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_ovl_in    = rsp_ovl_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      top_cmd       = '{start: 1'b0, op: OP_QUERY, coord: hi_ff};
      bot_cmd       = '{start: 1'b0, op: OP_QUERY, coord: lo_ff};
      case (state_ff)
         S_INIT: begin
            // wait for the clearing sweep of both trees
            if (top_stat.idle && bot_stat.idle) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               lo_in     = lo_new;
               hi_in     = hi_new;
               ovl_in    = '0;
               status_in = STATUS_OK;
               if (req_ch.cmd) begin
                  if (active_ff >= CNT_BITS'(MAX_ACTIVE)) begin
                     status_in = STATUS_FULL;
                     state_in  = S_OUT;
                  end else if (lo_new != hi_new) begin
                     // tops above the new bottom, bottoms at or above the new top
                     top_cmd  = '{start: 1'b1, op: OP_QUERY,
                                  coord: lo_new + COORD_BITS'(1)};
                     bot_cmd  = '{start: 1'b1, op: OP_QUERY, coord: hi_new};
                     state_in = S_QUERY;
                  end else begin
                     state_in = S_ACC;
                  end
               end else begin
                  if (active_ff == '0) begin
                     status_in = STATUS_NO_ACTIVE;
                     state_in  = S_OUT;
                  end else begin
                     top_cmd  = '{start: 1'b1, op: OP_LEAF, coord: hi_new};
                     bot_cmd  = '{start: 1'b1, op: OP_LEAF, coord: lo_new};
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_QUERY: begin
            if (walk_done) begin
               // clamp the difference at zero
               if (top_stat.value > bot_stat.value) begin
                  ovl_in = SUM_BITS'(top_stat.value - bot_stat.value);
               end else begin
                  ovl_in = '0;
               end
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            // saturate the pair total, then insert the interval
            pair_in   = pair_sum[TOTAL_BITS] ? '1 : pair_sum[TOTAL_BITS-1:0];
            active_in = active_ff + CNT_BITS'(1);
            top_cmd   = '{start: 1'b1, op: OP_INC, coord: hi_ff};
            bot_cmd   = '{start: 1'b1, op: OP_INC, coord: lo_ff};
            state_in  = S_UPD;
         end
         S_CHECK: begin
            if (walk_done) begin
               if (top_stat.value == '0 || bot_stat.value == '0) begin
                  // drop a removal whose top or bottom edge is not active
                  status_in = STATUS_NO_ACTIVE;
                  state_in  = S_OUT;
               end else begin
                  active_in = active_ff - CNT_BITS'(1);
                  top_cmd   = '{start: 1'b1, op: OP_DEC, coord: hi_ff};
                  bot_cmd   = '{start: 1'b1, op: OP_DEC, coord: lo_ff};
                  state_in  = S_UPD;
               end
            end
         end
         S_UPD: begin
            if (walk_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ovl_in    = (ovl_ff > SUM_BITS'(OVL_MAX)) ? OVL_BITS'(OVL_MAX)
                                                             : ovl_ff[OVL_BITS-1:0];
               rsp_total_in  = pair_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         pair_ff      <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pair_ff      <= pair_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      ovl_ff        <= ovl_in;
      status_ff     <= status_in;
      rsp_ovl_ff    <= rsp_ovl_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.new_overlaps = rsp_ovl_ff;
   assign rsp_ch.total_pairs  = rsp_total_ff;
   assign rsp_ch.status       = rsp_status_ff;

   `ROCT_ASSERT_IMPL(a_active_limit, clock, reset, 1'b1, active_ff <= CNT_BITS'(MAX_ACTIVE))
   `ROCT_ASSERT_NEXT(a_one_event, clock, reset, accept, !req_ready)
   `ROCT_ASSERT_IMPL(a_total_grows, clock, reset, !$past(reset), pair_ff >= $past(pair_ff))
   `ROCT_ASSERT_IMPL(a_full_status, clock, reset, state_ff == S_OUT && status_ff == STATUS_FULL, active_ff == CNT_BITS'(MAX_ACTIVE))

endmodule

// File: rtl/roct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module roct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/roct_walker.sv
// Count tree walker: one tree RAM plus the sequencer and adder that clear it,
// query suffix sums, read leaves and step counts along a leaf-to-root path.
// Depends on roct_pkg, roct_ram and the assertion macro header.
`include "rectangle_overlap_pair_counter_unit_assert.svh"

module roct_walker (
   input  logic                    clock,
   input  logic                    reset,
   input  roct_pkg::walk_cmd_type  cmd,
   output roct_pkg::walk_stat_type stat
);
   import roct_pkg::*;

   localparam logic [2:0] W_CLEAR    = 3'd0;
   localparam logic [2:0] W_IDLE     = 3'd1;
   localparam logic [2:0] W_QUERY    = 3'd2;
   localparam logic [2:0] W_UPDATE   = 3'd3;
   localparam logic [2:0] W_LEAF     = 3'd4;
   localparam logic [2:0] W_LEAF_CAP = 3'd5;

   localparam logic [ADDR_BITS-1:0] NODE_ROOT = ADDR_BITS'(1);

   logic [2:0]           state_ff, state_in;
   logic [ADDR_BITS-1:0] node_ff, node_in;
   logic [ADDR_BITS-1:0] wa_ff, wa_in;
   logic                 first_ff, first_in;
   logic                 pend_ff, pend_in;
   logic                 dec_ff, dec_in;
   logic                 done_ff, done_in;
   logic [CNT_BITS-1:0]  sum_ff, sum_in;

   logic                 ram_we;
   logic [ADDR_BITS-1:0] ram_wa;
   logic [ADDR_BITS-1:0] ram_ra;
   logic [CNT_BITS-1:0]  ram_wd;
   logic [CNT_BITS-1:0]  ram_rd;

   roct_ram #(
      .WIDTH (CNT_BITS),
      .DEPTH (TREE_DEPTH)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in = state_ff;
      node_in  = node_ff;
      wa_in    = wa_ff;
      first_in = 1'b0;
      pend_in  = 1'b0;
      dec_in   = dec_ff;
      done_in  = 1'b0;
      sum_in   = sum_ff;
      ram_we   = 1'b0;
      ram_wa   = wa_ff;
      ram_wd   = dec_ff ? ram_rd - CNT_BITS'(1) : ram_rd + CNT_BITS'(1);
      ram_ra   = node_ff;
      case (state_ff)
         W_CLEAR: begin
            // sweep every address once, writing zero
            ram_we  = 1'b1;
            ram_wa  = node_ff;
            ram_wd  = '0;
            node_in = node_ff + ADDR_BITS'(1);
            if (&node_ff) begin
               state_in = W_IDLE;
            end
         end
         W_IDLE: begin
            if (cmd.start) begin
               node_in = {1'b1, cmd.coord};
               sum_in  = '0;
               dec_in  = (cmd.op == OP_DEC);
               case (cmd.op)
                  OP_QUERY: begin
                     state_in = W_QUERY;
                     first_in = 1'b1;
                  end
                  OP_INC, OP_DEC: state_in = W_UPDATE;
                  default:        state_in = W_LEAF;
               endcase
            end
         end
         W_QUERY: begin
            // accumulate the read issued last cycle
            if (pend_ff) begin
               sum_in = sum_ff + ram_rd;
            end
            if (first_ff) begin
               ram_ra  = node_ff;
               pend_in = 1'b1;
            end else if (node_ff != NODE_ROOT) begin
               // right sibling counts only when walking up from a left child
               ram_ra  = node_ff | NODE_ROOT;
               pend_in = !node_ff[0];
               node_in = node_ff >> 1;
            end else begin
               state_in = W_IDLE;
               done_in  = 1'b1;
            end
         end
         W_UPDATE: begin
            // read node k while writing back node k-1
            ram_we = pend_ff;
            if (node_ff != '0) begin
               ram_ra  = node_ff;
               pend_in = 1'b1;
               wa_in   = node_ff;
               node_in = node_ff >> 1;
            end else begin
               state_in = W_IDLE;
               done_in  = 1'b1;
            end
         end
         W_LEAF: begin
            ram_ra   = node_ff;
            state_in = W_LEAF_CAP;
         end
         W_LEAF_CAP: begin
            sum_in   = ram_rd;
            done_in  = 1'b1;
            state_in = W_IDLE;
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_CLEAR;
         node_ff  <= '0;
         first_ff <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         first_ff <= first_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      wa_ff  <= wa_in;
      dec_ff <= dec_in;
      sum_ff <= sum_in;
   end

   assign stat.idle  = (state_ff == W_IDLE);
   assign stat.done  = done_ff;
   assign stat.value = sum_ff;

   `ROCT_ASSERT_IMPL(a_start_when_idle, clock, reset, cmd.start, state_ff == W_IDLE)
   `ROCT_ASSERT_IMPL(a_no_underflow, clock, reset, ram_we && state_ff == W_UPDATE && dec_ff, ram_rd != '0)
   `ROCT_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff)

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the rectangle overlap pair counter unit.
// Depends on roct_pkg, roct_if and the RTL top level; predicts every result in-line.
module testbench;
   import roct_pkg::*;

   localparam int  LEAVES         = 1 << COORD_BITS;
   localparam int  RANDOM_EVENTS  = 1300;
   localparam int  TAIL_EVENTS    = 60;
   localparam int  WATCHDOG_LIMIT = 6000;   // covers the tree clear after reset
   localparam int  DRAIN_CYCLES   = 60;
   localparam bit  CMD_END        = 1'b0;
   localparam bit  CMD_BEGIN      = 1'b1;

   typedef struct packed {
      logic [OVL_BITS-1:0]    overlaps;
      logic [TOTAL_BITS-1:0]  total;
      logic [STATUS_BITS-1:0] status;
   } pair_result_type;

   typedef struct {
      bit [COORD_BITS-1:0] lo;
      bit [COORD_BITS-1:0] hi;
   } y_span_type;

   // Edge-count tables, pair total and active count of the sweep; expected results queue.
   class pair_tally_checker;
      int unsigned     top_edges [LEAVES];
      int unsigned     bottom_edges [LEAVES];
      bit [31:0]       pair_sum;
      int unsigned     live_rects;
      pair_result_type pending [$];
      int unsigned     mismatches;

      function new();
         foreach (top_edges[i]) begin
            top_edges[i]    = 0;
            bottom_edges[i] = 0;
         end
         pair_sum   = 0;
         live_rects = 0;
         mismatches = 0;
      endfunction

      // Number of edges at y >= from in one table; from == LEAVES gives zero.
      function int unsigned edges_from(bit use_top, int from);
         int unsigned acc;
         acc = 0;
         for (int y = from; y < LEAVES; y++)
            acc += use_top ? top_edges[y] : bottom_edges[y];
         return acc;
      endfunction

      function void note_event(bit is_begin, bit [COORD_BITS-1:0] y_a,
                               bit [COORD_BITS-1:0] y_b);
         bit [COORD_BITS-1:0]    lo;
         bit [COORD_BITS-1:0]    hi;
         int unsigned            above;
         int unsigned            cleared;
         int unsigned            hits;
         logic [STATUS_BITS-1:0] code;
         bit [32:0]              widened;
         pair_result_type        res;
         lo    = (y_a > y_b) ? y_b : y_a;
         hi    = (y_a > y_b) ? y_a : y_b;
         hits  = 0;
         code  = STATUS_OK;
         if (is_begin) begin
            if (live_rects >= MAX_ACTIVE) begin
               code = STATUS_FULL;
            end else begin
               if (hi != lo) begin
                  above   = edges_from(1'b1, int'(lo) + 1);
                  cleared = edges_from(1'b0, int'(hi));
                  hits    = (above > cleared) ? above - cleared : 0;
               end
               widened  = {1'b0, pair_sum} + hits;
               pair_sum = widened[32] ? 32'hFFFF_FFFF : widened[31:0];
               top_edges[hi]++;
               bottom_edges[lo]++;
               live_rects++;
            end
         end else begin
            if (live_rects == 0 || top_edges[hi] == 0 || bottom_edges[lo] == 0) begin
               code = STATUS_NO_ACTIVE;
            end else begin
               top_edges[hi]--;
               bottom_edges[lo]--;
               live_rects--;
            end
         end
         res.overlaps = (hits > OVL_MAX) ? OVL_MAX[OVL_BITS-1:0] : hits[OVL_BITS-1:0];
         res.total    = pair_sum;
         res.status   = code;
         pending.insert(pending.size(), res);
      endfunction

      function void check_result(pair_result_type got);
         pair_result_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: ovl=%0d total=%0d status=%0d",
                        got.overlaps, got.total, got.status);
         end else begin
            want = pending.pop_front();
            if (got.overlaps !== want.overlaps || got.total !== want.total ||
                got.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected ovl=%0d total=%0d status=%0d,",
                            " got ovl=%0d total=%0d status=%0d"},
                           want.overlaps, want.total, want.status,
                           got.overlaps, got.total, got.status);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   idle_on;
   int   quiet_cycles;

   pair_tally_checker tally;
   y_span_type        live_spans [$];

   roct_req_if req_ch ();
   roct_rsp_if rsp_ch ();

   rectangle_overlap_pair_counter_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one sweep event, hold it until accepted, then log it with the predictor.
   // Valid stays high into the next transaction unless an idle burst is drawn.
   task automatic send_event(bit cmd, bit [COORD_BITS-1:0] y_a, bit [COORD_BITS-1:0] y_b);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.bottom_y <= y_a;
      req_ch.top_y    <= y_b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      tally.note_event(cmd, y_a, y_b);
   endtask

   // Result side: stall in random bursts while idling is enabled, else stay ready.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Check every accepted result transaction against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
         tally.check_result({rsp_ch.new_overlaps, rsp_ch.total_pairs, rsp_ch.status});
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int         roll;
      int         begin_pct;
      int         shape;
      int         idx;
      int         upper;
      y_span_type sp;

      tally           = new();
      idle_on         = 1'b1;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= CMD_END;
      req_ch.bottom_y <= '0;
      req_ch.top_y    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty removal, extremes, swapped and flat edges, touching
      // edges, removal of an interval whose leaves are not both active.
      send_event(CMD_END,   10'd0,    10'd0);      // nothing active
      send_event(CMD_BEGIN, 10'd0,    10'd1023);
      send_event(CMD_BEGIN, 10'd1023, 10'd0);      // swapped edges
      send_event(CMD_BEGIN, 10'd500,  10'd500);    // flat
      send_event(CMD_BEGIN, 10'd0,    10'd0);
      send_event(CMD_BEGIN, 10'd1023, 10'd1023);
      send_event(CMD_BEGIN, 10'd100,  10'd200);
      send_event(CMD_BEGIN, 10'd200,  10'd300);    // touches previous in y
      send_event(CMD_BEGIN, 10'd499,  10'd501);    // straddles the flat one
      send_event(CMD_BEGIN, 10'd600,  10'd500);    // bottom on the flat one
      send_event(CMD_BEGIN, 10'h2AA,  10'h155);
      send_event(CMD_END,   10'd555,  10'd777);    // never inserted
      send_event(CMD_END,   10'd150,  10'd300);    // top active, bottom not
      send_event(CMD_END,   10'd1023, 10'd0);      // swapped removal
      send_event(CMD_END,   10'd500,  10'd500);
      send_event(CMD_BEGIN, 10'd0,    10'd1);
      send_event(CMD_BEGIN, 10'd1022, 10'd1023);
      send_event(CMD_BEGIN, 10'd512,  10'd511);
      send_event(CMD_END,   10'd0,    10'd1023);
      send_event(CMD_END,   10'd0,    10'd1023);   // the previous removal took the last copy
      send_event(CMD_END,   10'd0,    10'd1023);
      send_event(CMD_BEGIN, 10'h155,  10'h2AA);

      // Random part: mostly well-formed sweeps that end intervals known to be
      // active, plus stray ends. Idling is off in every third stretch of 200 events.
      for (int n = 0; n < RANDOM_EVENTS; n++) begin
         idle_on = ((n / 200) % 3) != 2;
         roll    = $urandom_range(0, 99);
         if (roll < 5) begin
            send_event(CMD_END, COORD_BITS'($urandom_range(0, LEAVES - 1)),
                       COORD_BITS'($urandom_range(0, LEAVES - 1)));
         end else begin
            begin_pct = (live_spans.size() < 8) ? 80 : (live_spans.size() > 48) ? 25 : 50;
            if (live_spans.size() == 0 || $urandom_range(0, 99) < begin_pct) begin
               shape = $urandom_range(0, 19);
               sp.lo = COORD_BITS'($urandom_range(0, LEAVES - 1));
               if (shape < 3) begin
                  sp.hi = sp.lo;
               end else if (shape < 12) begin
                  upper = int'(sp.lo) + $urandom_range(1, 40);
                  sp.hi = COORD_BITS'((upper > LEAVES - 1) ? LEAVES - 1 : upper);
               end else begin
                  sp.hi = COORD_BITS'($urandom_range(0, LEAVES - 1));
               end
               if (sp.lo > sp.hi) begin
                  sp = '{lo: sp.hi, hi: sp.lo};
               end
               live_spans.insert(live_spans.size(), sp);
               if ($urandom_range(0, 1))
                  send_event(CMD_BEGIN, sp.hi, sp.lo);
               else
                  send_event(CMD_BEGIN, sp.lo, sp.hi);
            end else begin
               idx = $urandom_range(0, live_spans.size() - 1);
               sp  = live_spans[idx];
               live_spans.delete(idx);
               if ($urandom_range(0, 1))
                  send_event(CMD_END, sp.hi, sp.lo);
               else
                  send_event(CMD_END, sp.lo, sp.hi);
            end
         end
      end

      // Last part, no idling: a run of wide rectangles that all overlap, then
      // swap a few of them for full-height ones.
      idle_on = 1'b0;
      repeat (TAIL_EVENTS) begin
         sp.lo = COORD_BITS'($urandom_range(0, 60));
         sp.hi = COORD_BITS'($urandom_range(LEAVES - 64, LEAVES - 1));
         live_spans.insert(live_spans.size(), sp);
         send_event(CMD_BEGIN, sp.lo, sp.hi);
      end
      repeat (3) begin
         sp = live_spans.pop_back();
         send_event(CMD_END, sp.hi, sp.lo);
         send_event(CMD_BEGIN, 10'd0, 10'd1023);
      end
      send_event(CMD_END, COORD_BITS'($urandom_range(0, LEAVES - 1)),
                 COORD_BITS'($urandom_range(0, LEAVES - 1)));
      req_ch.valid <= 1'b0;

      // Drain: wait for outstanding results, then watch for any stray result before the verdict.
      while (tally.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tally.mismatches == 0 && tally.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
